[hdl/per_pkg.sv]
// Package for the point Euler rotation block: widths, payload types and the CORDIC table.
`default_nettype none
package per_pkg;

   localparam int CoordW       = 32;
   localparam int AngleW       = 16;
   localparam int TrigW        = 16;
   localparam int CordicStages = 24;
   localparam int CordicW      = 33;
   localparam int CordicLat    = CordicStages + 1;
   localparam int ProdW        = CoordW + TrigW;

   localparam logic signed [CordicW-1:0] CordicOneK = 33'sd652032874;
   localparam logic signed [TrigW-1:0]   Q15Max     = 16'sd32767;

   localparam logic [29:0] AtanTurns [CordicStages] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
      30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
      30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
      30'd166886,    30'd83443,     30'd41722,     30'd20861,
      30'd10430,     30'd5215,      30'd2608,      30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81
   };

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic [AngleW-1:0]        angle_type;
   typedef logic signed [TrigW-1:0]  trig_type;

   typedef struct packed {
      trig_type cos_v;
      trig_type sin_v;
   } trig_pair_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      angle_type angle_x;
      angle_type angle_y;
      angle_type angle_z;
   } req_type;

   typedef struct packed {
      coord_type rotated_x;
      coord_type rotated_y;
      coord_type rotated_z;
   } rsp_type;

endpackage
`default_nettype wire

[hdl/per_cordic.sv]
// Pipelined CORDIC: one iteration per stage, then Q1.15 rounding and quadrant mapping.
`default_nettype none
module per_cordic (
   input  wire                    clock,
   input  wire                    en,
   input  per_pkg::angle_type     angle,
   output per_pkg::trig_pair_type trig
);
   import per_pkg::*;

   logic [31:0]               a32;
   logic signed [CordicW-1:0] x_ff [CordicStages];
   logic signed [CordicW-1:0] y_ff [CordicStages];
   logic signed [CordicW-1:0] z_ff [CordicStages];
   logic [1:0]                quad_ff [CordicStages];
   logic signed [CordicW-1:0] x_in [CordicStages];
   logic signed [CordicW-1:0] y_in [CordicStages];
   logic signed [CordicW-1:0] z_in [CordicStages];
   logic signed [CordicW-1:0] x_src [CordicStages];
   logic signed [CordicW-1:0] y_src [CordicStages];
   logic signed [CordicW-1:0] z_src [CordicStages];
   logic signed [CordicW-1:0] dx [CordicStages];
   logic signed [CordicW-1:0] dy [CordicStages];
   logic signed [CordicW-1:0] at [CordicStages];
   logic signed [CordicW-1:0] c_rnd, s_rnd;
   trig_type                  c_q, s_q;
   trig_pair_type             trig_in, trig_ff;

   assign a32 = {angle, {(32-AngleW){1'b0}}};

   always_comb begin
      for (int i = 0; i < CordicStages; i++) begin
         if (i == 0) begin
            x_src[i] = CordicOneK;
            y_src[i] = '0;
            z_src[i] = $signed({3'b000, a32[29:0]});
         end else begin
            x_src[i] = x_ff[i-1];
            y_src[i] = y_ff[i-1];
            z_src[i] = z_ff[i-1];
         end
         dx[i] = y_src[i] >>> i;
         dy[i] = x_src[i] >>> i;
         at[i] = $signed({3'b000, AtanTurns[i]});
         if (!z_src[i][CordicW-1]) begin
            x_in[i] = x_src[i] - dx[i];
            y_in[i] = y_src[i] + dy[i];
            z_in[i] = z_src[i] - at[i];
         end else begin
            x_in[i] = x_src[i] + dx[i];
            y_in[i] = y_src[i] - dy[i];
            z_in[i] = z_src[i] + at[i];
         end
      end
   end

   // round half up to Q1.15 and clamp to +/-32767
   always_comb begin
      c_rnd = (x_ff[CordicStages-1] + 33'sd16384) >>> 15;
      s_rnd = (y_ff[CordicStages-1] + 33'sd16384) >>> 15;
      if (c_rnd > CordicW'(Q15Max))       c_q = Q15Max;
      else if (c_rnd < -CordicW'(Q15Max)) c_q = -Q15Max;
      else                                c_q = c_rnd[TrigW-1:0];
      if (s_rnd > CordicW'(Q15Max))       s_q = Q15Max;
      else if (s_rnd < -CordicW'(Q15Max)) s_q = -Q15Max;
      else                                s_q = s_rnd[TrigW-1:0];
      case (quad_ff[CordicStages-1])
         2'd0: begin
            trig_in.cos_v = c_q;  trig_in.sin_v = s_q;
         end
         2'd1: begin
            trig_in.cos_v = -s_q; trig_in.sin_v = c_q;
         end
         2'd2: begin
            trig_in.cos_v = -c_q; trig_in.sin_v = -s_q;
         end
         default: begin
            trig_in.cos_v = s_q;  trig_in.sin_v = -c_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < CordicStages; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
            quad_ff[i] <= (i == 0) ? a32[31:30] : quad_ff[(i == 0) ? 0 : i-1];
         end
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule
`default_nettype wire

[hdl/point_euler_rotate.sv]
// Top level: Euler X-Y-Z rotation of one Q16.16 point, fully pipelined.
//
// Takes one point and three angles per cycle while req_stall is low and
// returns the point rotated about X, then Y, then Z; a zero angle passes
// its coordinates unchanged. Three parallel CORDIC sine/cosine units
// (24 iterations plus rounding) are followed by a multiply stage and a
// round/saturate stage per axis, then the output register. Throughput is
// one beat per cycle. The last stage doubles as a skid register, so new beats
// are taken while a result waits on rsp_stall; req_stall rises only when that
// stage and the output register are both full and rsp_stall is high.
`default_nettype none
module point_euler_rotate (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  per_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output per_pkg::rsp_type rsp_data
);
   import per_pkg::*;

   localparam int RotStages = 6;

   typedef struct packed {
      logic signed [ProdW-1:0] p0;
      logic signed [ProdW-1:0] p1;
      logic signed [ProdW-1:0] p2;
      logic signed [ProdW-1:0] p3;
   } prod_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      zx;
      logic      zy;
      logic      zz;
   } pend_type;

   typedef struct packed {
      pend_type      pt;
      trig_pair_type ty;
      trig_pair_type tz;
      prod_type      pr;
   } stage_type;

   function automatic prod_type products(coord_type a, coord_type b, trig_pair_type t);
      prod_type r;
      r.p0 = a * t.cos_v;
      r.p1 = b * t.sin_v;
      r.p2 = a * t.sin_v;
      r.p3 = b * t.cos_v;
      return r;
   endfunction

   function automatic coord_type round_sat(logic signed [ProdW:0] acc);
      logic signed [ProdW:0]        t;
      logic signed [ProdW-15:0]     sh;
      t  = acc + (ProdW+1)'(16384);
      sh = t[ProdW:15];
      if (sh[ProdW-15:CoordW-1] == '0 || sh[ProdW-15:CoordW-1] == '1)
         return sh[CoordW-1:0];
      else if (sh[ProdW-15])
         return {1'b1, {(CoordW-1){1'b0}}};
      else
         return {1'b0, {(CoordW-1){1'b1}}};
   endfunction

   function automatic coord_type rot_a(prod_type p);
      return round_sat({p.p0[ProdW-1], p.p0} - {p.p1[ProdW-1], p.p1});
   endfunction

   function automatic coord_type rot_b(prod_type p);
      return round_sat({p.p2[ProdW-1], p.p2} + {p.p3[ProdW-1], p.p3});
   endfunction

   logic          adv;
   trig_pair_type trig_x, trig_y, trig_z;
   pend_type      dly_ff [CordicLat];
   logic          dly_v_ff [CordicLat];
   pend_type      head_in;
   stage_type     st_ff [RotStages];
   stage_type     st_in [RotStages];
   logic          st_v_ff [RotStages];
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   // advance the whole pipe unless the last stage is full and cannot drain
   assign adv       = !st_v_ff[RotStages-1] || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   per_cordic u_cordic_x (.clock(clock), .en(adv), .angle(req_data.angle_x), .trig(trig_x));
   per_cordic u_cordic_y (.clock(clock), .en(adv), .angle(req_data.angle_y), .trig(trig_y));
   per_cordic u_cordic_z (.clock(clock), .en(adv), .angle(req_data.angle_z), .trig(trig_z));

   always_comb begin
      head_in.x  = req_data.point_x;
      head_in.y  = req_data.point_y;
      head_in.z  = req_data.point_z;
      head_in.zx = (req_data.angle_x == '0);
      head_in.zy = (req_data.angle_y == '0);
      head_in.zz = (req_data.angle_z == '0);
   end

   always_comb begin
      // X axis: rotate (y, z)
      st_in[0].pt = dly_ff[CordicLat-1];
      st_in[0].ty = trig_y;
      st_in[0].tz = trig_z;
      st_in[0].pr = products(dly_ff[CordicLat-1].y, dly_ff[CordicLat-1].z, trig_x);
      st_in[1] = st_ff[0];
      if (!st_ff[0].pt.zx) begin
         st_in[1].pt.y = rot_a(st_ff[0].pr);
         st_in[1].pt.z = rot_b(st_ff[0].pr);
      end
      // Y axis: rotate (z, x)
      st_in[2]    = st_ff[1];
      st_in[2].pr = products(st_ff[1].pt.z, st_ff[1].pt.x, st_ff[1].ty);
      st_in[3]    = st_ff[2];
      if (!st_ff[2].pt.zy) begin
         st_in[3].pt.z = rot_a(st_ff[2].pr);
         st_in[3].pt.x = rot_b(st_ff[2].pr);
      end
      // Z axis: rotate (x, y)
      st_in[4]    = st_ff[3];
      st_in[4].pr = products(st_ff[3].pt.x, st_ff[3].pt.y, st_ff[3].tz);
      st_in[5]    = st_ff[4];
      if (!st_ff[4].pt.zz) begin
         st_in[5].pt.x = rot_a(st_ff[4].pr);
         st_in[5].pt.y = rot_b(st_ff[4].pr);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_ff[0] <= head_in;
         for (int i = 1; i < CordicLat; i++) dly_ff[i] <= dly_ff[i-1];
         for (int i = 0; i < RotStages; i++) st_ff[i] <= st_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CordicLat; i++) dly_v_ff[i] <= 1'b0;
         for (int i = 0; i < RotStages; i++) st_v_ff[i] <= 1'b0;
      end else if (adv) begin
         dly_v_ff[0] <= req_valid;
         for (int i = 1; i < CordicLat; i++) dly_v_ff[i] <= dly_v_ff[i-1];
         st_v_ff[0] <= dly_v_ff[CordicLat-1];
         for (int i = 1; i < RotStages; i++) st_v_ff[i] <= st_v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= st_v_ff[RotStages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_data_ff.rotated_x <= st_ff[RotStages-1].pt.x;
         rsp_data_ff.rotated_y <= st_ff[RotStages-1].pt.y;
         rsp_data_ff.rotated_z <= st_ff[RotStages-1].pt.z;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (st_v_ff[RotStages-1] && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a full, blocked tail");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      (st_v_ff[RotStages-1] && rsp_valid_ff && rsp_stall)
      |=> (st_v_ff[RotStages-1] && $stable(st_ff[RotStages-1].pt)))
      else $error("skid stage lost or changed a beat");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_v_ff[RotStages-1]))
      else $error("result raised with no beat in the last stage");
`endif

endmodule
`default_nettype wire
